// ===== sv/spsc_pkg.sv =====
// ----------------------------------------------------------------------------
// spsc_pkg: shared types, constants, microcode and helpers
// Control word layout, the microprogram and the fixed-point helper functions
// used by the switching servo controller.
// ----------------------------------------------------------------------------
package spsc_pkg;

	// fixed-point data widths
	localparam int DATA_W = 32;
	localparam int OPND_W = 33;
	localparam int PROD_W = 2 * OPND_W;
	localparam int INVP_W = 31;
	localparam int IDX_W  = 3;
	localparam int DECAY_W = 21;

	// filter and deadband constants
	localparam logic signed [OPND_W-1:0] DECAY_COEF = 33'sd1717987;
	localparam logic signed [OPND_W-1:0] RATE_COEF  = 33'sd644245094;
	localparam logic signed [OPND_W-1:0] RATE_LIMIT = 33'sd655;
	localparam logic signed [DATA_W-1:0] ERROR_LIMIT = 32'sd150;

	// register reset values
	localparam logic [INVP_W-1:0] INVP_RESET = 31'd65536000;
	localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

	// register index codes
	typedef enum logic [IDX_W-1:0] {
		REG_PROP_GAIN  = 3'd0,
		REG_INTEG_GAIN = 3'd1,
		REG_DERIV_GAIN = 3'd2,
		REG_INV_PERIOD = 3'd3,
		REG_WINDUP_LOW = 3'd4,
		REG_WINDUP_HIGH = 3'd5,
		REG_DRIVE_LOW  = 3'd6,
		REG_DRIVE_HIGH = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] kp;
		logic signed [DATA_W-1:0] ki;
		logic signed [DATA_W-1:0] kd;
		logic [INVP_W-1:0]        invp;
		logic signed [DATA_W-1:0] wind_lo;
		logic signed [DATA_W-1:0] wind_hi;
		logic signed [DATA_W-1:0] drv_lo;
		logic signed [DATA_W-1:0] drv_hi;
	} cfg_t;

	// multiplier operand selects
	typedef enum logic [2:0] {
		A_ZERO, A_DFB, A_ERRSUM, A_ERR, A_KD, A_LFT, A_REFDEC, A_FDIFF
	} sel_a_t;

	typedef enum logic [2:0] {
		B_ZERO, B_INVP, B_KP, B_VEL, B_DECAY, B_RATE, B_KI
	} sel_b_t;

	// datapath write-back operations
	typedef enum logic [3:0] {
		OP_NOP, OP_LOAD, OP_ERR, OP_VEL, OP_PI, OP_RELOAD, OP_SW_STICK,
		OP_SW_OVER, OP_DRV, OP_FILT, OP_DOT, OP_FINAL
	} op_t;

	// sequencer jump conditions
	typedef enum logic [2:0] {
		JC_NEXT, JC_ALWAYS, JC_WAIT_IN, JC_MODE, JC_WAIT_OUT
	} jc_t;

	localparam int NUM_STEPS = 13;
	localparam int STEP_W = $clog2(NUM_STEPS);
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_IDLE  = STEP_W'(0);
	localparam step_t STEP_OVER  = STEP_W'(6);
	localparam step_t STEP_DRV   = STEP_W'(7);

	typedef struct packed {
		logic   mul_en;
		sel_a_t mul_a;
		sel_b_t mul_b;
		op_t    op;
		jc_t    jc;
		step_t  target;
	} ctrl_t;

	typedef struct packed {
		ctrl_t word;
		logic  in_ready;
		logic  emit;
	} seq_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] drive;
		logic                     mode;
		logic                     dead;
	} res_t;

	function automatic ctrl_t uw(input logic en, input sel_a_t a, input sel_b_t b,
		input op_t op, input jc_t jc, input step_t tgt);
		ctrl_t w;
		w.mul_en = en;
		w.mul_a  = a;
		w.mul_b  = b;
		w.op     = op;
		w.jc     = jc;
		w.target = tgt;
		return w;
	endfunction

	// microprogram: one control word per step
	function automatic ctrl_t ucode(input step_t s);
		ctrl_t w;
		case (s)
			4'd0:  w = uw(1'b0, A_ZERO,   B_ZERO,  OP_LOAD,     JC_WAIT_IN,  STEP_IDLE);
			4'd1:  w = uw(1'b1, A_DFB,    B_INVP,  OP_ERR,      JC_NEXT,     STEP_IDLE);
			4'd2:  w = uw(1'b1, A_ERRSUM, B_KP,    OP_VEL,      JC_NEXT,     STEP_IDLE);
			4'd3:  w = uw(1'b1, A_ERR,    B_KP,    OP_PI,       JC_NEXT,     STEP_IDLE);
			4'd4:  w = uw(1'b1, A_KD,     B_VEL,   OP_RELOAD,   JC_MODE,     STEP_OVER);
			4'd5:  w = uw(1'b1, A_LFT,    B_DECAY, OP_SW_STICK, JC_ALWAYS,   STEP_DRV);
			4'd6:  w = uw(1'b1, A_LFT,    B_DECAY, OP_SW_OVER,  JC_NEXT,     STEP_IDLE);
			4'd7:  w = uw(1'b0, A_ZERO,   B_ZERO,  OP_DRV,      JC_NEXT,     STEP_IDLE);
			4'd8:  w = uw(1'b1, A_REFDEC, B_INVP,  OP_NOP,      JC_NEXT,     STEP_IDLE);
			4'd9:  w = uw(1'b0, A_ZERO,   B_ZERO,  OP_FILT,     JC_NEXT,     STEP_IDLE);
			4'd10: w = uw(1'b1, A_FDIFF,  B_RATE,  OP_NOP,      JC_NEXT,     STEP_IDLE);
			4'd11: w = uw(1'b1, A_ERR,    B_KI,    OP_DOT,      JC_NEXT,     STEP_IDLE);
			4'd12: w = uw(1'b0, A_ZERO,   B_ZERO,  OP_FINAL,    JC_WAIT_OUT, STEP_IDLE);
			default: w = uw(1'b0, A_ZERO, B_ZERO,  OP_NOP,      JC_ALWAYS,   STEP_IDLE);
		endcase
		return w;
	endfunction

	// sign extend a 32-bit value to product width
	function automatic logic signed [PROD_W-1:0] wide(input logic signed [DATA_W-1:0] x);
		return {{(PROD_W-DATA_W){x[DATA_W-1]}}, x};
	endfunction

	// saturate a product-width value to 32 signed bits
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
		if (x > wide(S32_MAX))
			return S32_MAX;
		else if (x < wide(S32_MIN))
			return S32_MIN;
		else
			return x[DATA_W-1:0];
	endfunction

	// limit to high first, then raise to low, so low wins
	function automatic logic signed [DATA_W-1:0] clamp32(input logic signed [DATA_W-1:0] x,
		input logic signed [DATA_W-1:0] lo, input logic signed [DATA_W-1:0] hi);
		logic signed [DATA_W-1:0] y;
		y = (x > hi) ? hi : x;
		if (y < lo)
			y = lo;
		return y;
	endfunction

endpackage

// ===== sv/switching_pid_servo_controller.sv =====
// ----------------------------------------------------------------------------
// switching_pid_servo_controller: microcoded switching PI-D servo loop
// Each item runs 12 steps of the 13-word microprogram (one of the two switch
// steps) on one registered 33x33 multiplier. A new input beat is accepted only
// once the previous result has been emitted; a stalled output beat holds the
// sequencer on its last step.
// Reset: asynchronous; gains clear, limits open, loop state and mode zero.
// ----------------------------------------------------------------------------
module switching_pid_servo_controller (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [spsc_pkg::DATA_W-1:0] target_angle,
	input  logic signed [spsc_pkg::DATA_W-1:0] measured_angle,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [spsc_pkg::DATA_W-1:0] drive,
	output logic                               overshoot_mode,
	output logic                               in_deadband,
	input  logic                               cfg_wr_en,
	input  logic [spsc_pkg::IDX_W-1:0]         cfg_index,
	input  logic [spsc_pkg::DATA_W-1:0]        cfg_data
);
	import spsc_pkg::*;

	cfg_t cfg_q;
	seq_t seq;
	res_t res;
	logic dp_mode;
	logic out_free;
	logic out_valid_q;
	logic signed [DATA_W-1:0] drive_q;
	logic mode_out_q, dead_out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp      <= '0;
			cfg_q.ki      <= '0;
			cfg_q.kd      <= '0;
			cfg_q.invp    <= INVP_RESET;
			cfg_q.wind_lo <= S32_MIN;
			cfg_q.wind_hi <= S32_MAX;
			cfg_q.drv_lo  <= S32_MIN;
			cfg_q.drv_hi  <= S32_MAX;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PROP_GAIN:   cfg_q.kp      <= cfg_data;
				REG_INTEG_GAIN:  cfg_q.ki      <= cfg_data;
				REG_DERIV_GAIN:  cfg_q.kd      <= cfg_data;
				REG_INV_PERIOD:  cfg_q.invp    <= cfg_data[INVP_W-1:0];
				REG_WINDUP_LOW:  cfg_q.wind_lo <= cfg_data;
				REG_WINDUP_HIGH: cfg_q.wind_hi <= cfg_data;
				REG_DRIVE_LOW:   cfg_q.drv_lo  <= cfg_data;
				REG_DRIVE_HIGH:  cfg_q.drv_hi  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign out_free = !out_valid_q || out_ready;

	spsc_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.mode     (dp_mode),
		.seq      (seq)
	);

	spsc_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (seq.word),
		.cfg            (cfg_q),
		.target_angle   (target_angle),
		.measured_angle (measured_angle),
		.mode           (dp_mode),
		.res            (res)
	);

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if (seq.emit) begin
			drive_q    <= res.drive;
			mode_out_q <= res.mode;
			dead_out_q <= res.dead;
		end
	end

	assign in_ready       = seq.in_ready;
	assign out_valid      = out_valid_q;
	assign drive          = drive_q;
	assign overshoot_mode = mode_out_q;
	assign in_deadband    = dead_out_q;

	// a result is only written into a free output slot
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		seq.emit |-> out_free)
		else $error("result written over a pending output beat");

	// an accepted beat keeps the sequencer busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("sequencer ready right after accepting a beat");

	// accepting and emitting never happen on the same step
	a_accept_not_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> !seq.emit)
		else $error("accept and emit on the same step");

	// deadband results carry zero drive
	a_dead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && in_deadband) |-> (drive == '0))
		else $error("nonzero drive inside deadband");

endmodule

// ===== sv/spsc_sequencer.sv =====
// ----------------------------------------------------------------------------
// spsc_sequencer: microprogram step counter
// Fetches one control word per step, resolves conditional jumps and gates
// the word while waiting on an input or output beat.
// ----------------------------------------------------------------------------
module spsc_sequencer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           out_free,
	input  logic           mode,
	output spsc_pkg::seq_t seq
);
	import spsc_pkg::*;

	step_t step_q;
	step_t step_d;
	ctrl_t word;
	logic  fire;

	// fetch and jump resolution
	always_comb begin
		word   = ucode(step_q);
		fire   = 1'b1;
		step_d = step_q + STEP_W'(1);
		case (word.jc)
			JC_NEXT: begin
				step_d = step_q + STEP_W'(1);
			end
			JC_ALWAYS: begin
				step_d = word.target;
			end
			JC_WAIT_IN: begin
				fire   = in_valid;
				step_d = in_valid ? step_q + STEP_W'(1) : step_q;
			end
			JC_MODE: begin
				step_d = mode ? word.target : step_q + STEP_W'(1);
			end
			JC_WAIT_OUT: begin
				fire   = out_free;
				step_d = out_free ? word.target : step_q;
			end
			default: begin
				step_d = STEP_IDLE;
			end
		endcase
	end

	// gated control word towards the datapath
	always_comb begin
		seq.word = word;
		if (!fire) begin
			seq.word.op     = OP_NOP;
			seq.word.mul_en = 1'b0;
		end
		seq.in_ready = (word.jc == JC_WAIT_IN);
		seq.emit     = fire && (word.op == OP_FINAL);
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

// ===== sv/spsc_datapath.sv =====
// ----------------------------------------------------------------------------
// spsc_datapath: shared multiplier and write-back registers
// One registered 33x33 multiplier with operand muxes, plus the per-step
// saturate, clamp and switching logic driven by the control word.
// ----------------------------------------------------------------------------
module spsc_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  spsc_pkg::ctrl_t                 ctrl,
	input  spsc_pkg::cfg_t                  cfg,
	input  logic signed [spsc_pkg::DATA_W-1:0] target_angle,
	input  logic signed [spsc_pkg::DATA_W-1:0] measured_angle,
	output logic                            mode,
	output spsc_pkg::res_t                  res
);
	import spsc_pkg::*;

	// loop state
	logic signed [DATA_W-1:0] lfb_q, lft_q, isum_q;
	logic                     mode_q;

	// per-item scratch
	logic signed [DATA_W-1:0] ref_q, fb_q, err_q, vel_q, phi_q, reload_q, kdv_q;
	logic signed [DATA_W-1:0] drv_q, filt_q;
	logic signed [DECAY_W-1:0] decay_q;
	logic                     dead_q;
	logic signed [PROD_W-1:0] prod_q;

	logic signed [OPND_W-1:0] opa, opb;
	logic signed [PROD_W-1:0] prod_full, prod_sh16;
	logic signed [DATA_W-1:0] prod_sat16;
	logic signed [OPND_W-1:0] dot;
	logic signed [DATA_W-1:0] isum_base;
	logic stick_flip, over_reload;

	// operand a select
	always_comb begin
		case (ctrl.mul_a)
			A_DFB:    opa = {fb_q[DATA_W-1], fb_q} - {lfb_q[DATA_W-1], lfb_q};
			A_ERRSUM: opa = OPND_W'(sat32(wide(err_q) + wide(isum_q)));
			A_ERR:    opa = OPND_W'(err_q);
			A_KD:     opa = OPND_W'(cfg.kd);
			A_LFT:    opa = OPND_W'(lft_q);
			A_REFDEC: opa = OPND_W'(ref_q) + OPND_W'(decay_q);
			A_FDIFF:  opa = {filt_q[DATA_W-1], filt_q} - {lft_q[DATA_W-1], lft_q};
			default:  opa = '0;
		endcase
	end

	// operand b select
	always_comb begin
		case (ctrl.mul_b)
			B_INVP:  opb = {2'b00, cfg.invp};
			B_KP:    opb = OPND_W'(cfg.kp);
			B_VEL:   opb = OPND_W'(vel_q);
			B_DECAY: opb = DECAY_COEF;
			B_RATE:  opb = RATE_COEF;
			B_KI:    opb = OPND_W'(cfg.ki);
			default: opb = '0;
		endcase
	end

	assign prod_full  = opa * opb;
	assign prod_sh16  = prod_q >>> 16;
	assign prod_sat16 = sat32(prod_sh16);
	assign dot        = prod_q[62:30];
	assign isum_base  = dead_q ? '0 : isum_q;

	// switching conditions on exact signs
	assign stick_flip = (cfg.ki == '0) || (err_q == '0) || (phi_q == '0) ||
		(cfg.ki[DATA_W-1] ^ err_q[DATA_W-1] ^ phi_q[DATA_W-1]);
	assign over_reload = (vel_q == '0) || (phi_q == '0) ||
		(vel_q[DATA_W-1] == phi_q[DATA_W-1]);

	// product register
	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q <= prod_full;
		end
	end

	// scratch write-back
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				ref_q <= target_angle;
				fb_q  <= measured_angle;
			end
			OP_ERR: begin
				err_q <= sat32(wide(ref_q) - wide(fb_q));
			end
			OP_VEL: begin
				vel_q <= prod_sat16;
			end
			OP_PI: begin
				phi_q <= clamp32(prod_sat16, cfg.wind_lo, cfg.wind_hi);
			end
			OP_RELOAD: begin
				reload_q <= prod_sat16;
			end
			OP_SW_STICK: begin
				kdv_q <= prod_sat16;
				if (stick_flip) begin
					phi_q <= (phi_q == S32_MIN) ? S32_MAX : -phi_q;
				end
			end
			OP_SW_OVER: begin
				kdv_q <= prod_sat16;
				if (over_reload) begin
					phi_q <= reload_q;
				end
			end
			OP_DRV: begin
				drv_q   <= clamp32(sat32(wide(phi_q) - wide(kdv_q)), cfg.drv_lo, cfg.drv_hi);
				decay_q <= prod_q[52:32];
			end
			OP_FILT: begin
				filt_q <= prod_sat16;
			end
			OP_DOT: begin
				dead_q <= (dot >= -RATE_LIMIT) && (dot <= RATE_LIMIT) &&
					(err_q >= -ERROR_LIMIT) && (err_q <= ERROR_LIMIT);
			end
			default: begin
			end
		endcase
	end

	// loop state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfb_q  <= '0;
			lft_q  <= '0;
			isum_q <= '0;
			mode_q <= 1'b0;
		end else begin
			case (ctrl.op)
				OP_SW_STICK: begin
					if (stick_flip) begin
						mode_q <= 1'b1;
					end
				end
				OP_SW_OVER: begin
					if (over_reload) begin
						mode_q <= 1'b0;
					end
				end
				OP_FINAL: begin
					isum_q <= sat32(wide(isum_base) + prod_sh16);
					lfb_q  <= fb_q;
					lft_q  <= filt_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign mode      = mode_q;
	assign res.drive = dead_q ? '0 : drv_q;
	assign res.mode  = mode_q;
	assign res.dead  = dead_q;

endmodule
